// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/teh_pkg.sv =====
// ----------------------------------------------------------------------------
// teh_pkg
// Types and codes shared by the timed event heap queue modules.
// ----------------------------------------------------------------------------
package teh_pkg;

    localparam int TIME_W  = 16;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 6;

    // one heap entry as stored in memory
    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [ID_W-1:0]   routine;
        logic [ID_W-1:0]   tag;
    } t_entry;

    // command codes
    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_PEND = 2'd1;
    localparam logic [1:0] MODE_EXEC = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_PAST  = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    // fired kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

endpackage

// ===== hw/rtl/teh_mem.sv =====
// ----------------------------------------------------------------------------
// teh_mem
// Heap storage: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module teh_mem #(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  teh_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output teh_pkg::t_entry o_rdata_a,
    output teh_pkg::t_entry o_rdata_b
);

    // entry 0 is unused, the heap is one-based
    teh_pkg::t_entry r_mem [DEPTH+1];
    teh_pkg::t_entry r_rdata_a;
    teh_pkg::t_entry r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, read data registered
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/timed_event_heap_queue.sv =====
// ----------------------------------------------------------------------------
// timed_event_heap_queue
// Discrete-event scheduler on a one-based binary min-heap held in memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Exactly one result
// follows for every command, shown for a single cycle with o_done high; the
// receiver cannot stall it, so it must sample it in that cycle. Offering a
// pending time, any rejected command and an enqueue into an empty heap
// finish straight from idle. Any other enqueue goes to S_INS, which moves the
// new event up the heap level by level and ends in S_FIN if it reaches the
// root. An execute goes to S_EXEC, where a tick or a pop that leaves at most
// one event ends; any other pop goes on to S_POP, which sinks the tail entry
// level by level and ends in S_FIN if it reaches the bottom. Both children of
// a heap level are read together on the two read ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_event_heap_queue #(
    parameter int QUEUE_DEPTH = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_trigger_time,
    input  logic [7:0]  i_routine_id,
    input  logic [7:0]  i_snapshot_tag,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [1:0]  o_fired_kind,
    output logic [15:0] o_fired_time,
    output logic [7:0]  o_fired_routine,
    output logic [7:0]  o_fired_tag,
    output logic [15:0] o_now_time,
    output logic        o_scan_request,
    output logic [5:0]  o_queue_count
);

    localparam int AW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [AW-1:0]                 r_count, n_count;
    logic [teh_pkg::TIME_W-1:0]    r_now, n_now;
    logic [teh_pkg::TIME_W-1:0]    r_pend, n_pend;
    logic [AW-1:0]                 r_pos, n_pos;
    teh_pkg::t_entry               r_item, n_item;
    logic                          r_done, n_done;
    logic [1:0]                    r_status, n_status;
    logic [1:0]                    r_kind, n_kind;
    teh_pkg::t_entry               r_fired, n_fired;
    logic                          r_scan, n_scan;

    // memory port controls
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    teh_pkg::t_entry               mem_wdata;
    logic [AW-1:0]                 mem_raddr_a;
    logic [AW-1:0]                 mem_raddr_b;
    teh_pkg::t_entry               mem_rdata_a;
    teh_pkg::t_entry               mem_rdata_b;

    // helper values for the sift steps
    logic                          accept;
    logic [AW-1:0]                 tail_pos;
    logic [AW:0]                   kid_w;
    logic [AW-1:0]                 kid_lo;
    logic [AW-1:0]                 kid_hi;
    logic                          pick_hi;
    teh_pkg::t_entry               kid_ent;
    logic [AW-1:0]                 kid_idx;
    logic [AW:0]                   gkid_w;
    logic [AW-1:0]                 gkid_lo;
    logic                          do_pop;
    logic [AW-1:0]                 cnt_dec;

    teh_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    assign accept   = start && !busy;
    assign tail_pos = r_count + AW'(1);
    assign cnt_dec  = r_count - AW'(1);

    // child selection for sift-down
    assign kid_w   = {r_pos, 1'b0};
    assign kid_lo  = kid_w[AW-1:0];
    assign kid_hi  = kid_lo + AW'(1);
    assign pick_hi = (kid_w != {1'b0, r_count}) &&
                     (mem_rdata_b.ev_time < mem_rdata_a.ev_time);
    assign kid_ent = pick_hi ? mem_rdata_b : mem_rdata_a;
    assign kid_idx = pick_hi ? kid_hi : kid_lo;
    assign gkid_w  = {kid_idx, 1'b0};
    assign gkid_lo = gkid_w[AW-1:0];

    // execute choice, top entry on port a
    assign do_pop = (r_pend == '0) || (r_pend >= mem_rdata_a.ev_time);

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_now       = r_now;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_item      = r_item;
        n_done      = 1'b0;
        n_status    = r_status;
        n_kind      = r_kind;
        n_fired     = r_fired;
        n_scan      = r_scan;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_item;
        mem_raddr_a = AW'(1);
        mem_raddr_b = r_count;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = teh_pkg::STATUS_OK;
                    n_kind   = teh_pkg::KIND_NONE;
                    n_fired  = '0;
                    n_scan   = 1'b0;
                    n_item   = {i_trigger_time, i_routine_id, i_snapshot_tag};
                    case (i_mode)
                        teh_pkg::MODE_ENQ: begin
                            if (r_count == AW'(QUEUE_DEPTH)) begin
                                n_status = teh_pkg::STATUS_FULL;
                                n_done   = 1'b1;
                            end else if (i_trigger_time < r_now) begin
                                n_status = teh_pkg::STATUS_PAST;
                                n_done   = 1'b1;
                            end else if (r_count == '0) begin
                                // empty heap: place at the root at once
                                mem_we    = 1'b1;
                                mem_waddr = AW'(1);
                                mem_wdata = {i_trigger_time, i_routine_id,
                                             i_snapshot_tag};
                                n_count   = tail_pos;
                                n_done    = 1'b1;
                            end else begin
                                n_pos       = tail_pos;
                                n_count     = tail_pos;
                                mem_raddr_a = tail_pos >> 1;
                                n_state     = S_INS;
                            end
                        end
                        teh_pkg::MODE_PEND: begin
                            if ((r_pend == '0) || (r_pend > i_trigger_time)) begin
                                n_pend = i_trigger_time;
                            end
                            n_done = 1'b1;
                        end
                        teh_pkg::MODE_EXEC: begin
                            if (r_count == '0) begin
                                n_status = teh_pkg::STATUS_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                mem_raddr_a = AW'(1);
                                mem_raddr_b = r_count;
                                n_state     = S_EXEC;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            // sift up: parent of r_pos is on port a
            S_INS: begin
                if (mem_rdata_a.ev_time > r_item.ev_time) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = mem_rdata_a;
                    n_pos     = r_pos >> 1;
                    if ((r_pos >> 1) == AW'(1)) begin
                        n_state = S_FIN;
                    end else begin
                        mem_raddr_a = r_pos >> 2;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_item;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // top on port a, tail on port b
            S_EXEC: begin
                n_scan = (r_now < mem_rdata_a.ev_time) &&
                         ((r_pend == '0) || (r_now < r_pend));
                if (do_pop) begin
                    n_kind  = teh_pkg::KIND_POP;
                    n_fired = mem_rdata_a;
                    n_now   = mem_rdata_a.ev_time;
                    n_count = cnt_dec;
                    n_item  = mem_rdata_b;
                    n_pos   = AW'(1);
                    if (cnt_dec == '0) begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (cnt_dec == AW'(1)) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(1);
                        mem_wdata = mem_rdata_b;
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        mem_raddr_a = AW'(2);
                        mem_raddr_b = AW'(3);
                        n_state     = S_POP;
                    end
                end else begin
                    n_kind          = teh_pkg::KIND_TICK;
                    n_fired         = '0;
                    n_fired.ev_time = r_pend;
                    n_now           = r_pend;
                    n_pend          = '0;
                    n_done          = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            // sift down: children of r_pos on ports a and b
            S_POP: begin
                if (r_item.ev_time > kid_ent.ev_time) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = kid_ent;
                    n_pos     = kid_idx;
                    if (gkid_w <= {1'b0, r_count}) begin
                        mem_raddr_a = gkid_lo;
                        mem_raddr_b = gkid_lo + AW'(1);
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_item;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            // place the carried entry at its final slot
            S_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_item;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_now   <= '0;
            r_pend  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_now   <= n_now;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_item   <= n_item;
        r_status <= n_status;
        r_kind   <= n_kind;
        r_fired  <= n_fired;
        r_scan   <= n_scan;
    end

    // result ports
    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_fired_kind    = r_kind;
    assign o_fired_time    = r_fired.ev_time;
    assign o_fired_routine = r_fired.routine;
    assign o_fired_tag     = r_fired.tag;
    assign o_now_time      = r_now;
    assign o_scan_request  = r_scan;
    assign o_queue_count   = teh_pkg::COUNT_W'(r_count);

    // checks
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > AW'(QUEUE_DEPTH),
        "heap count over depth")
    `ASSERT_CLK(a_pend_one_cycle, i_clk, i_rst_n,
        (accept && (i_mode == teh_pkg::MODE_PEND)) |=> (o_done && !busy),
        "offer result not in next cycle")
    `ASSERT_CLK(a_pop_has_kids, i_clk, i_rst_n,
        (r_state == S_POP) |-> (kid_w <= {1'b0, r_count}),
        "sift-down past last entry")
    `ASSERT_CLK(a_done_ends_work, i_clk, i_rst_n,
        (busy && n_done) |=> (o_done && !busy),
        "result strobe without return to idle")
    `ASSERT_CLK(a_none_zero, i_clk, i_rst_n,
        (o_done && (o_fired_kind == teh_pkg::KIND_NONE)) |-> (o_fired_time == '0),
        "idle result carries a time")

endmodule
